// ----- src/per_cpu_page_allocator_defines.svh -----
// Assertion macros shared by the page allocator RTL.
`ifndef PER_CPU_PAGE_ALLOCATOR_DEFINES_SVH
`define PER_CPU_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcpa: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcpa: next-cycle check failed");

`endif

// ----- src/pcpa_pkg.sv -----
// Shared constants, codes and types of the per-CPU page allocator.
package pcpa_pkg;

	localparam int CPU_COUNT     = 8;
	localparam int CPU_W         = 3;
	localparam int PAGE_CAPACITY = 32768;
	localparam int SLOT_W        = $clog2(PAGE_CAPACITY);
	localparam int ADDR_W        = 32;
	localparam int PAGE_SHIFT    = 12;
	localparam int PN_W          = 20;
	localparam int END_W         = 21;
	localparam int CFG_IDX_W     = 1;

	localparam logic [PN_W-1:0]  FIRST_PAGE_RST = 20'd524320;
	localparam logic [END_W-1:0] END_PAGE_RST   = 21'd557056;

	// transaction kinds
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_INIT  = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_OOM     = 2'd1;
	localparam logic [1:0] STATUS_BADFREE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE   = 1'd1;

	// one entry of the next-link store
	typedef struct packed {
		logic              vld;
		logic [SLOT_W-1:0] slot;
	} link_t;

	// request from the controller to the link memory
	typedef struct packed {
		logic              re;
		logic              we;
		logic [SLOT_W-1:0] addr;
		link_t             wdata;
	} ram_req_t;

endpackage

// ----- src/pcpa_link_ram.sv -----
// Single-port synchronous RAM with registered read data.
module pcpa_link_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ----- src/pcpa_ctrl.sv -----
// Allocator sequencer: list heads, alloc/free/init steps and result register.
module pcpa_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic [pcpa_pkg::CPU_W-1:0]     cpu,
	input  logic [pcpa_pkg::ADDR_W-1:0]    address,
	input  logic [pcpa_pkg::PN_W-1:0]      first_page,
	input  logic [pcpa_pkg::END_W-1:0]     end_page,
	output pcpa_pkg::ram_req_t             ram_req,
	input  pcpa_pkg::link_t                ram_rdata,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pcpa_pkg::ADDR_W-1:0]    page_address,
	output logic [1:0]                     status,
	output logic [pcpa_pkg::CPU_W-1:0]     source_cpu
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_INIT,
		S_RESP
	} state_t;

	state_t state_q;

	// accepted transaction
	logic [1:0]                  kind_q;
	logic [pcpa_pkg::CPU_W-1:0]  cpu_q;
	logic [pcpa_pkg::ADDR_W-1:0] addr_q;

	// list heads
	logic [pcpa_pkg::SLOT_W-1:0] head_q     [pcpa_pkg::CPU_COUNT];
	logic [pcpa_pkg::CPU_COUNT-1:0] head_vld_q;

	// pop and init bookkeeping
	logic [pcpa_pkg::CPU_W-1:0]  from_q;
	logic [pcpa_pkg::SLOT_W-1:0] pop_slot_q;
	logic [pcpa_pkg::SLOT_W-1:0] cnt_q;
	logic [pcpa_pkg::SLOT_W-1:0] last_q;

	// pending result
	logic [pcpa_pkg::ADDR_W-1:0] res_addr_q;
	logic [1:0]                  res_status_q;
	logic [pcpa_pkg::CPU_W-1:0]  res_src_q;

	// output register
	logic                        out_valid_q;
	logic [pcpa_pkg::ADDR_W-1:0] out_addr_q;
	logic [1:0]                  out_status_q;
	logic [pcpa_pkg::CPU_W-1:0]  out_src_q;

	// steal search
	logic                        found;
	logic [pcpa_pkg::CPU_W-1:0]  from;
	logic [pcpa_pkg::CPU_W-1:0]  cand;

	// free address check
	logic [pcpa_pkg::PN_W-1:0]   pn;
	logic [pcpa_pkg::END_W-1:0]  pn_off;
	logic                        bad_free;
	logic [pcpa_pkg::SLOT_W-1:0] free_slot;

	// init range
	logic [pcpa_pkg::END_W-1:0]  rng;
	logic                        rng_nonempty;
	logic [pcpa_pkg::SLOT_W-1:0] rng_last;

	// popped page byte address
	logic [pcpa_pkg::END_W-1:0]  pop_pn;

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign page_address = out_addr_q;
	assign status       = out_status_q;
	assign source_cpu   = out_src_q;

	// own list first, else the nearest non-empty list after cpu, wrapping
	always_comb begin
		cand  = '0;
		found = head_vld_q[cpu_q];
		from  = cpu_q;
		if (!found) begin
			for (int k = pcpa_pkg::CPU_COUNT - 1; k >= 1; k--) begin
				cand = cpu_q + pcpa_pkg::CPU_W'(k);
				if (head_vld_q[cand]) begin
					found = 1'b1;
					from  = cand;
				end
			end
		end
	end

	// free: aligned, inside [first_page, end_page) and inside the store
	always_comb begin
		pn        = addr_q[pcpa_pkg::ADDR_W-1:pcpa_pkg::PAGE_SHIFT];
		pn_off    = {1'b0, pn} - {1'b0, first_page};
		free_slot = pn_off[pcpa_pkg::SLOT_W-1:0];
		bad_free  = (addr_q[pcpa_pkg::PAGE_SHIFT-1:0] != '0) ||
			(pn < first_page) || ({1'b0, pn} >= end_page) ||
			(pn_off[pcpa_pkg::END_W-1:pcpa_pkg::SLOT_W] != '0);
	end

	// init: page count clipped to the store size
	always_comb begin
		rng          = end_page - {1'b0, first_page};
		rng_nonempty = (end_page > {1'b0, first_page});
		if (rng > pcpa_pkg::END_W'(pcpa_pkg::PAGE_CAPACITY)) begin
			rng_last = pcpa_pkg::SLOT_W'(pcpa_pkg::PAGE_CAPACITY - 1);
		end else begin
			rng_last = pcpa_pkg::SLOT_W'(rng - pcpa_pkg::END_W'(1));
		end
	end

	assign pop_pn = {1'b0, first_page} + pcpa_pkg::END_W'(pop_slot_q);

	// link memory requests
	always_comb begin
		ram_req = '0;
		case (state_q)
			S_EXEC: begin
				if (kind_q == pcpa_pkg::KIND_ALLOC && found) begin
					ram_req.re   = 1'b1;
					ram_req.addr = head_q[from];
				end else if (kind_q == pcpa_pkg::KIND_FREE && !bad_free) begin
					ram_req.we         = 1'b1;
					ram_req.addr       = free_slot;
					ram_req.wdata.vld  = head_vld_q[cpu_q];
					ram_req.wdata.slot = head_q[cpu_q];
				end
			end
			S_INIT: begin
				ram_req.we         = 1'b1;
				ram_req.addr       = cnt_q;
				ram_req.wdata.vld  = head_vld_q[cpu_q];
				ram_req.wdata.slot = head_q[cpu_q];
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	// sequencer, list heads and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_vld_q   <= '0;
			for (int i = 0; i < pcpa_pkg::CPU_COUNT; i++) begin
				head_q[i] <= '0;
			end
			out_valid_q  <= 1'b0;
			kind_q       <= '0;
			cpu_q        <= '0;
			addr_q       <= '0;
			from_q       <= '0;
			pop_slot_q   <= '0;
			cnt_q        <= '0;
			last_q       <= '0;
			res_addr_q   <= '0;
			res_status_q <= pcpa_pkg::STATUS_OK;
			res_src_q    <= '0;
			out_addr_q   <= '0;
			out_status_q <= pcpa_pkg::STATUS_OK;
			out_src_q    <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						cpu_q   <= cpu;
						addr_q  <= address;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_addr_q   <= '0;
					res_status_q <= pcpa_pkg::STATUS_OK;
					res_src_q    <= '0;
					state_q      <= S_RESP;
					case (kind_q)
						pcpa_pkg::KIND_ALLOC: begin
							if (found) begin
								from_q     <= from;
								pop_slot_q <= head_q[from];
								state_q    <= S_POP;
							end else begin
								res_status_q <= pcpa_pkg::STATUS_OOM;
							end
						end
						pcpa_pkg::KIND_FREE: begin
							if (bad_free) begin
								res_status_q <= pcpa_pkg::STATUS_BADFREE;
							end else begin
								head_q[cpu_q]     <= free_slot;
								head_vld_q[cpu_q] <= 1'b1;
							end
						end
						pcpa_pkg::KIND_INIT: begin
							if (rng_nonempty) begin
								cnt_q   <= '0;
								last_q  <= rng_last;
								state_q <= S_INIT;
							end
						end
						default: begin
							res_status_q <= pcpa_pkg::STATUS_OK;
						end
					endcase
				end
				S_POP: begin
					// link of the popped page becomes the new head
					head_q[from_q]     <= ram_rdata.slot;
					head_vld_q[from_q] <= ram_rdata.vld;
					res_addr_q <= {pop_pn[pcpa_pkg::PN_W-1:0],
						pcpa_pkg::PAGE_SHIFT'(0)};
					res_src_q  <= from_q;
					state_q    <= S_RESP;
				end
				S_INIT: begin
					head_q[cpu_q]     <= cnt_q;
					head_vld_q[cpu_q] <= 1'b1;
					cnt_q             <= cnt_q + pcpa_pkg::SLOT_W'(1);
					if (cnt_q == last_q) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						out_src_q    <= res_src_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/per_cpu_page_allocator.sv -----
// Top level of the per-CPU page allocator: config registers, sequencer, link memory.
//
//  channel   signals                                  handshake
//  in        kind, cpu, address                       in_valid / in_ready
//  out       page_address, status, source_cpu         out_valid / out_ready
//  cfg       cfg_index, cfg_data                      cfg_we, no wait
//
// Alloc steps through execute, pop (one link-memory read) and response states;
// free and other kinds skip the pop. Init writes one link entry per cycle for
// n = min(end_page - first_page, PAGE_CAPACITY) pages. One transaction is in
// work at a time; the output register lets the next one be accepted while a
// result waits. Lists are empty after reset; the link memory needs no clearing.
`include "per_cpu_page_allocator_defines.svh"

module per_cpu_page_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        kind,
	input  logic [pcpa_pkg::CPU_W-1:0]        cpu,
	input  logic [pcpa_pkg::ADDR_W-1:0]       address,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pcpa_pkg::ADDR_W-1:0]       page_address,
	output logic [1:0]                        status,
	output logic [pcpa_pkg::CPU_W-1:0]        source_cpu,
	input  logic                              cfg_we,
	input  logic [pcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcpa_pkg::END_W-1:0]        cfg_data
);

	logic [pcpa_pkg::PN_W-1:0]  first_page_q;
	logic [pcpa_pkg::END_W-1:0] end_page_q;
	pcpa_pkg::ram_req_t         ram_req;
	pcpa_pkg::link_t            ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= pcpa_pkg::FIRST_PAGE_RST;
			end_page_q   <= pcpa_pkg::END_PAGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pcpa_pkg::CFG_FIRST_PAGE: first_page_q <= cfg_data[pcpa_pkg::PN_W-1:0];
				pcpa_pkg::CFG_END_PAGE:   end_page_q   <= cfg_data;
				default:                  end_page_q   <= end_page_q;
			endcase
		end
	end

	pcpa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.cpu          (cpu),
		.address      (address),
		.first_page   (first_page_q),
		.end_page     (end_page_q),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.page_address (page_address),
		.status       (status),
		.source_cpu   (source_cpu)
	);

	pcpa_link_ram #(
		.WIDTH ($bits(pcpa_pkg::link_t)),
		.DEPTH (pcpa_pkg::PAGE_CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.re    (ram_req.re),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	// checks
	`PCPA_ASSERT_NOW(a_ram_one_op, clk, arst_n, ram_req.we, !ram_req.re)
	`PCPA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`PCPA_ASSERT_NOW(a_no_page_on_error, clk, arst_n,
		out_valid && (status != pcpa_pkg::STATUS_OK), page_address == '0 && source_cpu == '0)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the per-CPU page allocator: predicted replies checked per field.
`timescale 1ns / 1ps

module testbench;
	import pcpa_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         TOP_PAGE    = (1 << PN_W) - 1;
	localparam int         HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CPU_W-1:0]  cpu;
		logic [ADDR_W-1:0] address;
	} page_request_t;

	typedef struct packed {
		logic [ADDR_W-1:0] page_address;
		logic [1:0]        status;
		logic [CPU_W-1:0]  source_cpu;
	} page_reply_t;

	typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PATTERN} ready_mode_t;

	// DUT ports, all driven from time zero
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [1:0]           kind         = '0;
	logic [CPU_W-1:0]     cpu          = '0;
	logic [ADDR_W-1:0]    address      = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [ADDR_W-1:0]    page_address;
	logic [1:0]           status;
	logic [CPU_W-1:0]     source_cpu;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [END_W-1:0]     cfg_data     = '0;

	per_cpu_page_allocator dut (.*);

	// Allocator shadow state: per-CPU list heads and the slot link store
	logic [SLOT_W-1:0] head_slot [CPU_COUNT];
	logic              head_ok   [CPU_COUNT] = '{default: 1'b0};
	logic [SLOT_W-1:0] link_slot [PAGE_CAPACITY];
	logic              link_ok   [PAGE_CAPACITY];
	logic [PN_W-1:0]   cur_first = FIRST_PAGE_RST;
	logic [END_W-1:0]  cur_end   = END_PAGE_RST;
	int                pages_listed = 0;

	page_request_t     request_queue[$];
	page_reply_t       awaited_replies[$];
	logic [ADDR_W-1:0] loaned_pages[$];     // pages handed out and not yet returned
	int                requests_made   = 0;
	int                results_checked = 0;
	int                failures        = 0;
	int                hold_trigger    = 0;

	// driver and receiver state
	page_request_t     next_req;
	int                burst_left = 0;
	int                gap_left   = 0;
	page_reply_t       want;
	int                hold_seen  = 0;
	int                hold_left  = 0;
	int                mode_left  = 0;
	ready_mode_t       ready_mode = READY_ALWAYS;
	logic [7:0]        ready_mask = 8'h01;

	function automatic logic [ADDR_W-1:0] page_to_address(input logic [PN_W-1:0] pn);
		return {pn, {PAGE_SHIFT{1'b0}}};
	endfunction

	function automatic logic [CPU_W-1:0] any_cpu();
		return CPU_W'($urandom_range(0, CPU_COUNT - 1));
	endfunction

	function automatic void push_page(input int unsigned c, input logic [SLOT_W-1:0] s);
		link_slot[s] = head_slot[c];
		link_ok[s]   = head_ok[c];
		head_slot[c] = s;
		head_ok[c]   = 1'b1;
	endfunction

	// Updates the shadow state for one transaction and returns its reply
	function automatic page_reply_t predict_page_result(input logic [1:0] k,
			input logic [CPU_W-1:0] c, input logic [ADDR_W-1:0] a);
		page_reply_t       r;
		int unsigned       src;
		int unsigned       pn;
		int unsigned       span;
		logic [SLOT_W-1:0] s;
		bit                hit;
		r   = '0;
		hit = 1'b0;
		src = c;
		case (k)
			KIND_ALLOC: begin
				// own list first, then steal from c+1 onward with wrap
				for (int i = 0; i < CPU_COUNT && !hit; i++) begin
					src = (c + i) % CPU_COUNT;
					hit = head_ok[src];
				end
				if (hit) begin
					s              = head_slot[src];
					head_slot[src] = link_slot[s];
					head_ok[src]   = link_ok[s];
					r.page_address = page_to_address(cur_first + s);
					r.source_cpu   = CPU_W'(src);
					pages_listed--;
					loaned_pages.push_back(r.page_address);
				end else begin
					r.status = STATUS_OOM;
				end
			end
			KIND_FREE: begin
				pn = a[ADDR_W-1:PAGE_SHIFT];
				if (a[PAGE_SHIFT-1:0] != '0 || pn < cur_first || pn >= cur_end ||
						pn - cur_first >= PAGE_CAPACITY) begin
					r.status = STATUS_BADFREE;
				end else begin
					push_page(c, SLOT_W'(pn - cur_first));
					pages_listed++;
				end
			end
			KIND_INIT: begin
				if (cur_end > cur_first) begin
					span = cur_end - cur_first;
					if (span > PAGE_CAPACITY)
						span = PAGE_CAPACITY;
					for (int unsigned i = 0; i < span; i++)
						push_page(c, SLOT_W'(i));
					pages_listed += span;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Driver: offers queued requests in bursts; predicts each accepted transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				awaited_replies.push_back(predict_page_result(kind, cpu, address));
			if (in_valid && !in_ready) begin
				// offer stays up unchanged until taken
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (request_queue.size() != 0) begin
				next_req = request_queue.pop_front();
				kind     <= next_req.kind;
				cpu      <= next_req.cpu;
				address  <= next_req.address;
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each reply against the oldest prediction, then picks out_ready
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_replies.size() == 0) begin
					$error("reply with none expected: page_address %h status %0d source_cpu %0d",
						page_address, status, source_cpu);
					failures++;
				end else begin
					want = awaited_replies.pop_front();
					results_checked++;
					if (page_address !== want.page_address) begin
						$error("page_address: expected %h, actual %h",
							want.page_address, page_address);
						failures++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						failures++;
					end
					if (source_cpu !== want.source_cpu) begin
						$error("source_cpu: expected %0d, actual %0d",
							want.source_cpu, source_cpu);
						failures++;
					end
				end
			end
			// long hold-off on request, otherwise a stall pattern that changes now and then
			if (hold_seen != hold_trigger) begin
				hold_seen = hold_trigger;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 120);
				ready_mask = 8'($urandom()) | 8'h01;
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (ready_mode)
					READY_ALWAYS: out_ready <= 1'b1;
					READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
					READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default: begin
						ready_mask = {ready_mask[6:0], ready_mask[7]};
						out_ready <= ready_mask[0];
					end
				endcase
			end
		end
	end

	task automatic queue_request(input logic [1:0] k, input logic [CPU_W-1:0] c,
			input logic [ADDR_W-1:0] a);
		request_queue.push_back('{k, c, a});
		requests_made++;
	endtask

	// Waits until every transaction has its reply, then lets the block settle
	task automatic wait_quiet();
		while (results_checked != requests_made)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Register write; only called while the block is idle
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [END_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FIRST_PAGE)
			cur_first = value[PN_W-1:0];
		else
			cur_end = value;
	endtask

	// One phase on a small fresh range: init, then allocs, returns of loaned pages,
	// bad frees and unused kinds. A clean phase drains every list at the end; a
	// corrupt one mixes in double frees and repeated inits, which leave lists that share pages.
	task automatic run_pool_phase(input int n_items, input bit corrupt, input bit squeeze);
		int unsigned       span;
		int unsigned       base;
		int unsigned       pn;
		int unsigned       pick;
		int unsigned       alloc_share;
		int unsigned       idx;
		logic [ADDR_W-1:0] addr;
		span = $urandom_range(1, 40);
		case ($urandom_range(0, 3))
			0:       base = 0;
			1:       base = TOP_PAGE + 1 - span;
			default: base = $urandom_range(0, TOP_PAGE + 1 - span);
		endcase
		// top data bit is outside first_page and must be dropped
		write_register(CFG_FIRST_PAGE, {1'($urandom_range(0, 1)), PN_W'(base)});
		write_register(CFG_END_PAGE, END_W'(base + span));
		loaned_pages.delete();
		queue_request(KIND_INIT, any_cpu(), $urandom());
		if (squeeze)
			hold_trigger++;
		alloc_share = $urandom_range(20, 60);
		repeat (n_items) begin
			while (request_queue.size() > 2)
				@(posedge clk);
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				// bad free: misaligned, or aligned outside the range
				if ($urandom_range(0, 1)) begin
					addr = $urandom();
					if (addr[PAGE_SHIFT-1:0] == '0)
						addr[0] = 1'b1;
				end else begin
					pn = $urandom_range(0, TOP_PAGE);
					if (pn >= cur_first && pn < cur_end)
						pn = (cur_end > TOP_PAGE) ? cur_first - 1 : cur_end;
					addr = page_to_address(pn);
				end
				queue_request(KIND_FREE, any_cpu(), addr);
			end else if (pick < 9) begin
				queue_request(KIND_UNUSED, any_cpu(), $urandom());
			end else if (corrupt && pick < 12) begin
				queue_request(KIND_INIT, any_cpu(), $urandom());
			end else if (corrupt && pick < 15) begin
				pn = cur_first + $urandom_range(0, cur_end - cur_first - 1);
				queue_request(KIND_FREE, any_cpu(), page_to_address(pn));
			end else if (loaned_pages.size() == 0 || pick < 15 + alloc_share) begin
				queue_request(KIND_ALLOC, any_cpu(), $urandom());
			end else begin
				idx  = $urandom_range(0, loaned_pages.size() - 1);
				addr = loaned_pages[idx];
				loaned_pages.delete(idx);
				queue_request(KIND_FREE, any_cpu(), addr);
			end
		end
		wait_quiet();
		if (!corrupt) begin
			repeat (pages_listed + 1) queue_request(KIND_ALLOC, any_cpu(), $urandom());
			wait_quiet();
		end
	endtask

	// Stimulus
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset range: empty lists, bad frees, own pop and wrap-around steal
		queue_request(KIND_ALLOC, 3'd0, 32'h0000_0000);
		queue_request(KIND_FREE,  3'd3, 32'h8002_0000);   // first page
		queue_request(KIND_FREE,  3'd7, 32'h87FF_F000);   // last page
		queue_request(KIND_FREE,  3'd1, 32'h8002_0800);   // misaligned
		queue_request(KIND_FREE,  3'd1, 32'h8001_F000);   // below range
		queue_request(KIND_FREE,  3'd1, 32'h8800_0000);   // at end_page
		queue_request(KIND_FREE,  3'd1, 32'hFFFF_FFFF);
		queue_request(KIND_FREE,  3'd1, 32'h0000_0000);
		queue_request(KIND_ALLOC, 3'd7, 32'hFFFF_FFFF);
		queue_request(KIND_ALLOC, 3'd7, 32'h0000_0000);   // steals from cpu 3
		queue_request(KIND_ALLOC, 3'd2, 32'h0000_0000);
		queue_request(KIND_UNUSED, 3'd6, 32'hFFFF_F000);
		wait_quiet();

		// single top page
		write_register(CFG_FIRST_PAGE, END_W'(TOP_PAGE));
		write_register(CFG_END_PAGE, END_W'(TOP_PAGE + 1));
		queue_request(KIND_INIT,  3'd5, 32'hFFFF_FFFF);
		queue_request(KIND_ALLOC, 3'd4, 32'h0000_0000);
		queue_request(KIND_FREE,  3'd6, 32'hFFFF_F000);
		queue_request(KIND_FREE,  3'd6, 32'hFFFF_E000);   // below range
		queue_request(KIND_ALLOC, 3'd6, 32'h0000_0000);
		wait_quiet();

		// empty range: end_page below first_page
		write_register(CFG_END_PAGE, '0);
		queue_request(KIND_INIT,  3'd2, 32'h0000_0000);
		queue_request(KIND_ALLOC, 3'd2, 32'h0000_0000);
		queue_request(KIND_FREE,  3'd0, 32'hFFFF_F000);
		wait_quiet();

		// random traffic on small ranges
		for (int p = 0; p < 6; p++)
			run_pool_phase(70, 1'b0, p == 1 || p == 4);
		run_pool_phase(60, 1'b1, 1'b0);

		// range larger than the link store, then a first_page change under live lists
		write_register(CFG_FIRST_PAGE, '0);
		write_register(CFG_END_PAGE, END_W'(TOP_PAGE + 1));
		queue_request(KIND_INIT,  3'd0, 32'h0000_0000);
		queue_request(KIND_ALLOC, 3'd0, 32'h0000_0000);
		queue_request(KIND_FREE,  3'd3, 32'h0800_0000);   // slot past the store
		queue_request(KIND_FREE,  3'd3, 32'h0000_0000);
		queue_request(KIND_ALLOC, 3'd3, 32'h0000_0000);
		wait_quiet();
		write_register(CFG_FIRST_PAGE, END_W'(TOP_PAGE));
		queue_request(KIND_ALLOC, 3'd0, 32'h0000_0000);   // address wraps past 32 bits
		queue_request(KIND_ALLOC, 3'd1, 32'h0000_0000);
		wait_quiet();

		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
